@@ rtl/core/rotation_angle_column_tracker_assert.svh @@
`ifndef ROTATION_ANGLE_COLUMN_TRACKER_ASSERT_SVH
`define ROTATION_ANGLE_COLUMN_TRACKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define RACT_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rotation angle column tracker check failed");

// next-cycle implication, sampled on clk, off during rst
`define RACT_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rotation angle column tracker check failed");

`endif

@@ rtl/core/ract_pkg.sv @@
package ract_pkg;

  localparam int ANGLE_STEPS  = 4096;
  localparam int COLUMN_COUNT = 256;
  localparam int ANGLE_W      = $clog2(ANGLE_STEPS);
  localparam int COLUMN_W     = $clog2(COLUMN_COUNT);
  localparam int TIME_W       = 48;
  localparam int ACC_W        = TIME_W + 1;
  localparam int UNIT_W       = TIME_W + 2;
  localparam int SPEED_W      = 12;
  localparam int INTERVAL_W   = 32;
  localparam int DRIFT_SHIFT  = 5;
  localparam int CNT_W        = $clog2(ACC_W);
  localparam int MUL_IDX_W    = $clog2(ANGLE_W);
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_DRIFT_STEP     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DRIFT_INTERVAL = 2'd1;

  typedef enum logic [1:0] {
    REQ_PULSE  = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_kind_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [TIME_W-1:0] timestamp;
  } req_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]  angle;
    logic [COLUMN_W-1:0] column;
    logic [COLUMN_W-1:0] opposite_column;
    logic                column_changed;
    logic                valid_res;
  } res_t;

  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_LOAD  = 4'd1,
    OP_CLEAR = 4'd2,
    OP_PULSE = 4'd3,
    OP_DIFF  = 4'd4,
    OP_DRIFT = 4'd5,
    OP_MUL   = 4'd6,
    OP_ADD   = 4'd7,
    OP_REM   = 4'd8,
    OP_FRAC  = 4'd9,
    OP_DONE  = 4'd10
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [MUL_IDX_W-1:0] mul_idx;
  } ctrl_t;

  typedef struct packed {
    logic td_zero;
  } stat_t;

endpackage

@@ rtl/core/ract_seq.sv @@
module ract_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic [1:0]      req_kind,
  output logic            req_stall,
  input  logic            res_busy,
  input  ract_pkg::stat_t stat,
  output ract_pkg::ctrl_t ctrl
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIFF  = 8'b0000_0010,
    S_DRIFT = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_ADD   = 8'b0001_0000,
    S_REM   = 8'b0010_0000,
    S_FRAC  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t                       state, state_next;
  logic [ract_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic                         is_pulse, is_pulse_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      is_pulse <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      is_pulse <= is_pulse_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    is_pulse_next = is_pulse;
    ctrl.op       = ract_pkg::OP_NONE;
    ctrl.mul_idx  = cnt[ract_pkg::MUL_IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (ract_pkg::req_kind_t'(req_kind))
            ract_pkg::REQ_PULSE: begin
              ctrl.op       = ract_pkg::OP_LOAD;
              is_pulse_next = 1'b1;
              state_next    = S_DIFF;
            end
            ract_pkg::REQ_TICK: begin
              ctrl.op       = ract_pkg::OP_LOAD;
              is_pulse_next = 1'b0;
              state_next    = S_DIFF;
            end
            ract_pkg::REQ_CLEAR: begin
              ctrl.op = ract_pkg::OP_CLEAR;
            end
            ract_pkg::REQ_UNUSED: begin
              ctrl.op = ract_pkg::OP_NONE;
            end
            default: begin
              ctrl.op = ract_pkg::OP_NONE;
            end
          endcase
        end
      end
      S_DIFF: begin
        ctrl.op    = is_pulse ? ract_pkg::OP_PULSE : ract_pkg::OP_DIFF;
        state_next = is_pulse ? S_IDLE : S_DRIFT;
      end
      S_DRIFT: begin
        ctrl.op    = ract_pkg::OP_DRIFT;
        cnt_next   = '0;
        state_next = stat.td_zero ? S_DONE : S_MUL;
      end
      S_MUL: begin
        ctrl.op = ract_pkg::OP_MUL;
        if (cnt == ract_pkg::CNT_W'(ract_pkg::ANGLE_W - 1)) begin
          cnt_next   = '0;
          state_next = S_ADD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ADD: begin
        ctrl.op    = ract_pkg::OP_ADD;
        cnt_next   = '0;
        state_next = S_REM;
      end
      S_REM: begin
        ctrl.op = ract_pkg::OP_REM;
        if (cnt == ract_pkg::CNT_W'(ract_pkg::ACC_W - 1)) begin
          cnt_next   = '0;
          state_next = S_FRAC;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_FRAC: begin
        ctrl.op = ract_pkg::OP_FRAC;
        if (cnt == ract_pkg::CNT_W'(ract_pkg::ANGLE_W - 1)) begin
          cnt_next   = '0;
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DONE: begin
        if (!res_busy) begin
          ctrl.op    = ract_pkg::OP_DONE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/ract_dp.sv @@
module ract_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  ract_pkg::ctrl_t                     ctrl,
  input  logic [ract_pkg::TIME_W-1:0]         req_time,
  input  logic                                cfg_write,
  input  logic [ract_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ract_pkg::CFG_DATA_W-1:0]     cfg_data,
  output ract_pkg::stat_t                     stat,
  output ract_pkg::res_t                      result
);

  logic [ract_pkg::SPEED_W-1:0]    drift_step;
  logic [ract_pkg::INTERVAL_W-1:0] drift_interval;

  logic [ract_pkg::TIME_W-1:0]     last_pulse_time;
  logic [ract_pkg::TIME_W-1:0]     turn_duration;
  logic [ract_pkg::ANGLE_W-1:0]    drift_offset;
  logic [ract_pkg::TIME_W-1:0]     last_drift_time;
  logic [ract_pkg::COLUMN_W:0]     previous_column;

  logic [ract_pkg::TIME_W-1:0]     now;
  logic [ract_pkg::TIME_W-1:0]     diff;
  logic [ract_pkg::ACC_W-1:0]      acc;
  logic [ract_pkg::TIME_W-1:0]     rem;
  logic [ract_pkg::ANGLE_W-1:0]    quot;

  logic [ract_pkg::UNIT_W-1:0]     unit_a, unit_b;
  logic                            unit_sub;
  logic [ract_pkg::UNIT_W:0]       unit_sum;
  logic                            unit_ge;

  logic [ract_pkg::ACC_W-1:0]      drift_due;
  logic [ract_pkg::COLUMN_W-1:0]   col;

  // shared add / subtract unit
  always_comb begin
    unit_a   = '0;
    unit_b   = '0;
    unit_sub = 1'b0;
    unique case (ctrl.op)
      ract_pkg::OP_PULSE, ract_pkg::OP_DIFF: begin
        unit_a   = {2'b00, now};
        unit_b   = {2'b00, last_pulse_time};
        unit_sub = 1'b1;
      end
      ract_pkg::OP_MUL: begin
        unit_a = {1'b0, acc};
        unit_b = drift_offset[ctrl.mul_idx] ? {2'b00, turn_duration} : '0;
      end
      ract_pkg::OP_ADD: begin
        unit_a = {1'b0, acc};
        unit_b = {2'b00, diff};
      end
      ract_pkg::OP_REM: begin
        unit_a   = {1'b0, rem, acc[ract_pkg::ACC_W-1]};
        unit_b   = {2'b00, turn_duration};
        unit_sub = 1'b1;
      end
      ract_pkg::OP_FRAC: begin
        unit_a   = {1'b0, rem, 1'b0};
        unit_b   = {2'b00, turn_duration};
        unit_sub = 1'b1;
      end
      default: begin
        unit_sub = 1'b0;
      end
    endcase
  end

  assign unit_sum = {1'b0, unit_a} + ({1'b0, unit_b} ^ {(ract_pkg::UNIT_W + 1){unit_sub}})
                  + (ract_pkg::UNIT_W + 1)'(unit_sub);
  assign unit_ge  = ~unit_sum[ract_pkg::UNIT_W];

  assign drift_due = {1'b0, last_drift_time}
                   + ract_pkg::ACC_W'(drift_interval >> ract_pkg::DRIFT_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      drift_step     <= '0;
      drift_interval <= '0;
    end else if (cfg_write) begin
      if (cfg_index == ract_pkg::REG_DRIFT_STEP) begin
        drift_step <= cfg_data[ract_pkg::SPEED_W-1:0];
      end else if (cfg_index == ract_pkg::REG_DRIFT_INTERVAL) begin
        drift_interval <= cfg_data[ract_pkg::INTERVAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pulse_time <= '0;
      turn_duration   <= '0;
      drift_offset    <= '0;
      last_drift_time <= '0;
      previous_column <= '1;
    end else begin
      unique case (ctrl.op)
        ract_pkg::OP_CLEAR: begin
          drift_offset <= '0;
        end
        ract_pkg::OP_PULSE: begin
          turn_duration   <= unit_sum[ract_pkg::TIME_W-1:0];
          last_pulse_time <= now;
        end
        ract_pkg::OP_DRIFT: begin
          if ({1'b0, now} > drift_due) begin
            drift_offset    <= drift_offset + drift_step;
            last_drift_time <= now;
          end
        end
        ract_pkg::OP_DONE: begin
          if (!stat.td_zero) begin
            previous_column <= {1'b0, col};
          end
        end
        default: begin
          previous_column <= previous_column;
        end
      endcase
    end
  end

  // working registers of the shared unit
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      ract_pkg::OP_LOAD: begin
        now <= req_time;
      end
      ract_pkg::OP_DIFF: begin
        diff <= unit_sum[ract_pkg::TIME_W-1:0];
      end
      ract_pkg::OP_DRIFT: begin
        acc <= '0;
      end
      ract_pkg::OP_MUL: begin
        acc <= unit_sum[ract_pkg::ACC_W:1];
      end
      ract_pkg::OP_ADD: begin
        acc <= unit_sum[ract_pkg::ACC_W-1:0];
        rem <= '0;
      end
      ract_pkg::OP_REM: begin
        rem <= unit_ge ? unit_sum[ract_pkg::TIME_W-1:0] : unit_a[ract_pkg::TIME_W-1:0];
        acc <= {acc[ract_pkg::ACC_W-2:0], 1'b0};
      end
      ract_pkg::OP_FRAC: begin
        rem  <= unit_ge ? unit_sum[ract_pkg::TIME_W-1:0] : unit_a[ract_pkg::TIME_W-1:0];
        quot <= {quot[ract_pkg::ANGLE_W-2:0], unit_ge};
      end
      default: begin
        now <= now;
      end
    endcase
  end

  assign stat.td_zero = (turn_duration == '0);

  assign col = quot[ract_pkg::ANGLE_W-1 -: ract_pkg::COLUMN_W];

  always_comb begin
    if (stat.td_zero) begin
      result = '0;
    end else begin
      result.angle           = quot;
      result.column          = col;
      result.opposite_column = col + ract_pkg::COLUMN_W'(ract_pkg::COLUMN_COUNT / 2);
      result.column_changed  = ({1'b0, col} != previous_column);
      result.valid_res       = 1'b1;
    end
  end

endmodule

@@ rtl/core/rotation_angle_column_tracker.sv @@
// Angle and column tracker for a spinning LED bar. A pulse request records the
// length of the revolution that just ended; a clear request zeroes the drift
// offset; a tick request applies the drift step when it is due, then returns
// angle, column, opposite column, a column-changed flag and valid_res. For a
// tick, one 50-bit add/subtract unit does the drift-to-time multiply (one bit
// of the offset per cycle), the reduction modulo the turn length (one bit per
// cycle) and the fraction of the turn, plus accept, difference, drift, add and
// result steps; the result step waits while an earlier result is stalled.
// Before a nonzero revolution length is known a tick skips the arithmetic and
// returns all zeros. Requests are taken while a result still waits in the
// output register; configuration writes are always ready.
module rotation_angle_column_tracker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  ract_pkg::req_t                   req_data,
  output logic                             res_valid,
  input  logic                             res_stall,
  output ract_pkg::res_t                   res_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ract_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ract_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ract_pkg::ctrl_t ctrl;
  ract_pkg::stat_t stat;
  ract_pkg::res_t  result;
  logic            res_busy;

  assign cfg_ready = 1'b1;
  assign res_busy  = res_valid && res_stall;

  ract_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_kind  (req_data.req_type),
    .req_stall (req_stall),
    .res_busy  (res_busy),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  ract_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .req_time  (req_data.timestamp),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.op == ract_pkg::OP_DONE) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == ract_pkg::OP_DONE) begin
      res_data <= result;
    end
  end

endmodule

@@ rtl/core/ract_checker.sv @@
`include "rotation_angle_column_tracker_assert.svh"

module ract_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_stall,
  input ract_pkg::req_t                   req_data,
  input logic                             res_valid,
  input logic                             res_stall,
  input ract_pkg::res_t                   res_data,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [ract_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [ract_pkg::CFG_DATA_W-1:0]  cfg_data
);

  `RACT_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_data))

  `RACT_ASSERT_IMP(a_unknown_zero, res_valid && !res_data.valid_res, res_data.angle == '0 && res_data.column == '0 && res_data.opposite_column == '0 && !res_data.column_changed)

  `RACT_ASSERT_IMP(a_opposite, res_valid && res_data.valid_res, res_data.opposite_column == res_data.column + ract_pkg::COLUMN_W'(ract_pkg::COLUMN_COUNT / 2))

  `RACT_ASSERT_IMP(a_col_from_angle, res_valid, res_data.column == res_data.angle[ract_pkg::ANGLE_W-1 -: ract_pkg::COLUMN_W])

  `RACT_ASSERT_NXT(a_busy_after_tick, req_valid && !req_stall && req_data.req_type == ract_pkg::REQ_TICK, req_stall)

endmodule

bind rotation_angle_column_tracker ract_checker u_ract_checker (.*);

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ract_pkg::*;

  localparam int DRAIN_PAD      = 100;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 192;
  localparam int DIR_ROWS       = 20;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [TIME_W-1:0]      TIME_MAX    = {TIME_W{1'b1}};

  typedef struct packed {
    req_kind_t         kind;
    logic [TIME_W-1:0] ts;
    logic              typed;
    res_t              pos;
  } dir_row_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_stall;
  req_t                   req_data  = '0;
  logic                   res_valid;
  logic                   res_stall = 1'b0;
  res_t                   res_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // typed expectation travelling with the request on the wire
  logic row_typed = 1'b0;
  res_t row_pos   = '0;

  int send_idle  = 0;
  int stall_pct  = 0;
  int fault_count = 0;
  int quiet_cycles = 0;

  // tracker copy
  logic [SPEED_W-1:0]    cfg_speed      = '0;
  logic [INTERVAL_W-1:0] cfg_interval   = '0;
  logic [TIME_W-1:0]     trk_last_pulse = '0;
  logic [TIME_W-1:0]     trk_turn       = '0;
  logic [ANGLE_W-1:0]    trk_drift      = '0;
  logic [TIME_W-1:0]     trk_last_drift = '0;
  logic [COLUMN_W:0]     trk_prev_col   = '1;

  res_t pending_positions[$];
  dir_row_t dir_table[DIR_ROWS];

  rotation_angle_column_tracker u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit tracker_step(input req_t rq, output res_t pos);
    logic [TIME_W-1:0] since;
    logic [TIME_W:0]   drift_due;
    logic [63:0]       drift_t;
    logic [63:0]       elapsed;
    logic [63:0]       rem;
    logic [63:0]       ang;
    logic [63:0]       col;
    pos = '0;
    case (rq.req_type)
      REQ_PULSE: begin
        trk_turn       = rq.timestamp - trk_last_pulse;
        trk_last_pulse = rq.timestamp;
        return 1'b0;
      end
      REQ_CLEAR: begin
        trk_drift = '0;
        return 1'b0;
      end
      REQ_TICK: begin
        drift_due = {1'b0, trk_last_drift} + (TIME_W+1)'(cfg_interval >> DRIFT_SHIFT);
        if ({1'b0, rq.timestamp} > drift_due) begin
          trk_drift      = trk_drift + cfg_speed;
          trk_last_drift = rq.timestamp;
        end
        if (trk_turn == '0) begin
          return 1'b1;
        end
        since   = rq.timestamp - trk_last_pulse;
        drift_t = (64'(trk_drift) * 64'(trk_turn)) >> ANGLE_W;
        elapsed = drift_t + 64'(since);
        rem     = elapsed % 64'(trk_turn);
        ang     = (rem << ANGLE_W) / 64'(trk_turn);
        col     = (rem << COLUMN_W) / 64'(trk_turn);
        pos.angle           = ang[ANGLE_W-1:0];
        pos.column          = col[COLUMN_W-1:0];
        pos.opposite_column = col[COLUMN_W-1:0] + COLUMN_W'(COLUMN_COUNT / 2);
        pos.column_changed  = ({1'b0, col[COLUMN_W-1:0]} != trk_prev_col);
        pos.valid_res       = 1'b1;
        trk_prev_col        = {1'b0, col[COLUMN_W-1:0]};
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    res_t pos;
    res_t want;
    bit   busy;
    if (!rst) begin
      busy = 1'b0;
      if (cfg_valid && cfg_ready) begin
        busy = 1'b1;
        if (cfg_index == REG_DRIFT_STEP) cfg_speed = cfg_data[SPEED_W-1:0];
        else if (cfg_index == REG_DRIFT_INTERVAL) cfg_interval = cfg_data;
      end
      if (req_valid && !req_stall) begin
        busy = 1'b1;
        if (tracker_step(req_data, pos)) pending_positions.push_back(row_typed ? row_pos : pos);
      end
      if (res_valid && !res_stall) begin
        busy = 1'b1;
        if (pending_positions.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("unexpected result: angle %0d column %0d opposite %0d changed %0b valid %0b",
                     res_data.angle, res_data.column, res_data.opposite_column,
                     res_data.column_changed, res_data.valid_res);
        end else begin
          want = pending_positions.pop_front();
          if (res_data.angle !== want.angle || res_data.column !== want.column ||
              res_data.opposite_column !== want.opposite_column ||
              res_data.column_changed !== want.column_changed ||
              res_data.valid_res !== want.valid_res) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
              $display("mismatch: exp angle %0d col %0d opp %0d chg %0b vld %0b / %s%0d %0d %0d %0b %0b",
                       want.angle, want.column, want.opposite_column, want.column_changed,
                       want.valid_res, "got ", res_data.angle, res_data.column,
                       res_data.opposite_column, res_data.column_changed, res_data.valid_res);
          end
        end
      end
      if (busy) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_drift(input logic [SPEED_W-1:0] speed, input logic [INTERVAL_W-1:0] ivl);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    write_reg(REG_DRIFT_STEP, {junk[CFG_DATA_W-1:SPEED_W], speed});
    write_reg(REG_DRIFT_INTERVAL, ivl);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_request(input req_t rq, input logic typed, input res_t pos);
    req_valid <= 1'b1;
    req_data  <= rq;
    row_typed <= typed;
    row_pos   <= pos;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_positions.size() != 0);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  initial begin
    int                ph;
    int                k;
    int                roll;
    int unsigned       period;
    int unsigned       to_pulse;
    int unsigned       step;
    logic [TIME_W-1:0] now_ts;
    logic [SPEED_W-1:0] speed;
    logic [INTERVAL_W-1:0] ivl;
    req_t              rq;
    int                idle_tab[4];
    int                stall_tab[4];

    idle_tab  = '{0, 54, 0, 19};
    stall_tab = '{0, 0, 54, 19};

    dir_table = '{
      '{REQ_TICK,   48'd0,        1'b1, '{12'd0,    8'd0,   8'd0,   1'b0, 1'b0}},
      '{REQ_TICK,   TIME_MAX,     1'b1, '{12'd0,    8'd0,   8'd0,   1'b0, 1'b0}},
      '{REQ_CLEAR,  48'd0,        1'b0, '0},
      '{REQ_UNUSED, TIME_MAX,     1'b0, '0},
      '{REQ_PULSE,  48'd1000,     1'b0, '0},
      '{REQ_PULSE,  48'd2000,     1'b0, '0},
      '{REQ_TICK,   48'd2000,     1'b1, '{12'd0,    8'd0,   8'd128, 1'b1, 1'b1}},
      '{REQ_TICK,   48'd2500,     1'b1, '{12'd2048, 8'd128, 8'd0,   1'b1, 1'b1}},
      '{REQ_TICK,   48'd2500,     1'b1, '{12'd2048, 8'd128, 8'd0,   1'b0, 1'b1}},
      '{REQ_TICK,   48'd3000,     1'b1, '{12'd0,    8'd0,   8'd128, 1'b1, 1'b1}},
      // time going backwards
      '{REQ_TICK,   48'd1999,     1'b0, '0},
      // several whole turns elapsed
      '{REQ_TICK,   48'd12250,    1'b0, '0},
      '{REQ_UNUSED, 48'd0,        1'b0, '0},
      '{REQ_PULSE,  48'd0,        1'b0, '0},
      '{REQ_TICK,   TIME_MAX,     1'b0, '0},
      '{REQ_CLEAR,  TIME_MAX,     1'b0, '0},
      // same timestamp twice: length unknown again
      '{REQ_PULSE,  48'd0,        1'b0, '0},
      '{REQ_TICK,   48'd5,        1'b1, '{12'd0,    8'd0,   8'd0,   1'b0, 1'b0}},
      '{REQ_PULSE,  TIME_MAX,     1'b0, '0},
      '{REQ_TICK,   48'd0,        1'b0, '0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    set_drift('0, '0);
    send_idle = 19;
    stall_pct = 19;
    @(posedge clk);

    for (k = 0; k < DIR_ROWS; k++) begin
      rq.req_type  = dir_table[k].kind;
      rq.timestamp = dir_table[k].ts;
      send_request(rq, dir_table[k].typed, dir_table[k].pos);
    end
    wait_drained();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin speed = 12'd0;   ivl = 32'd0;         end
        1: begin speed = 12'h7FF; ivl = 32'd0;         end
        2: begin speed = 12'h800; ivl = 32'hFFFF_FFFF; end
        3: begin speed = SPEED_W'($urandom_range(4095)); ivl = $urandom_range(0, 32 * 5000); end
        4: begin speed = 12'd1;   ivl = $urandom;      end
        5: begin speed = 12'hFFF; ivl = 32'd31;        end
        default: begin speed = SPEED_W'($urandom_range(4095)); ivl = $urandom; end
      endcase
      set_drift(speed, ivl);
      send_idle = idle_tab[ph % 4];
      stall_pct = stall_tab[ph % 4];
      period = (ph == 5) ? $urandom_range(16, 32'hFFFF_FFF0) : $urandom_range(16, 40000);
      now_ts = TIME_W'({$urandom, $urandom});
      @(posedge clk);

      // zero-length turn under the phase's drift setting
      rq.timestamp = now_ts;
      rq.req_type  = REQ_PULSE;
      send_request(rq, 1'b0, '0);
      send_request(rq, 1'b0, '0);
      rq.req_type  = REQ_TICK;
      rq.timestamp = now_ts + 1;
      send_request(rq, 1'b0, '0);
      to_pulse = $urandom_range(0, period);

      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) begin
          req_valid <= 1'b0;
          do @(posedge clk); while (pending_positions.size() != 0);
        end
        roll = $urandom_range(99);
        if (roll < 12) begin
          rq.req_type  = 2'($urandom_range(3));
          rq.timestamp = TIME_W'({$urandom, $urandom});
        end else if (roll < 14) begin
          rq.req_type  = REQ_CLEAR;
          rq.timestamp = now_ts;
        end else begin
          step = $urandom_range(0, period / 4 + 1);
          if (step >= to_pulse) begin
            now_ts      += to_pulse;
            rq.req_type  = REQ_PULSE;
            to_pulse     = period - period / 32 + $urandom_range(0, period / 16);
          end else begin
            now_ts      += step;
            to_pulse    -= step;
            rq.req_type  = REQ_TICK;
          end
          rq.timestamp = now_ts;
        end
        send_request(rq, 1'b0, '0);
      end
      wait_drained();
    end

    if (fault_count == 0 && pending_positions.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
